// ===== rtl/core/omsa_pkg.sv =====
// Shared constants, codes and types of the offset mean-square accumulator.
`default_nettype none

package omsa_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OFFSET_W   = 25;
    localparam int VOFF_W     = 24;
    localparam int DIFF_W     = 26;
    localparam int MAG_W      = DIFF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = 60;
    localparam int WIN_W      = 13;
    localparam int CALIB_W    = 32;
    localparam int CNT_W      = 16;
    localparam int DIVIDEND_W = CALIB_W + FRAC_BITS;

    // Limits
    localparam int MAX_WINDOW = 4096;
    localparam int MAX_CALIB  = 65535;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Mode codes
    localparam logic [1:0] MODE_MEASURE = 2'd0;
    localparam logic [1:0] MODE_CALIB   = 2'd1;
    localparam logic [1:0] MODE_FINISH  = 2'd2;

    // Register indexes
    localparam logic REG_WINDOW  = 1'b0;
    localparam logic REG_VOFFSET = 1'b1;

    // Lane control strobes
    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic clear;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/offset_mean_square_accumulator.sv =====
// Top level of the offset mean-square accumulator: control, calibration, merge.
`default_nettype none

// Four-lane mean-square accumulator with DC offset calibration. A measure
// transaction passes offset subtract, 26x26 square and saturating add in
// each lane; a batch result is held in an output register so the next
// transaction is taken while it waits, and the accumulate step waits only when
// a new batch completes while the previous result is still stalled. A
// calibration sample is summed, and mode three dropped, without leaving idle. A
// finish transaction with a nonzero count waits in the divide state for the
// 40-step restoring dividers (one per current lane). Sums saturate at 2^60-1;
// the window is clamped to 1..4096. Registers: 0x0 window_samples, 0x4
// voltage_offset (signed Q.8).

module offset_mean_square_accumulator
    import omsa_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // Sample channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 mode,
    input  wire logic signed [SAMPLE_W-1:0] sample_current_1,
    input  wire logic signed [SAMPLE_W-1:0] sample_current_2,
    input  wire logic signed [SAMPLE_W-1:0] sample_voltage_1,
    input  wire logic signed [SAMPLE_W-1:0] sample_voltage_2,
    // Batch channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [SUM_W-1:0]                sum_current_1,
    output logic [SUM_W-1:0]                sum_current_2,
    output logic [SUM_W-1:0]                sum_voltage_1,
    output logic [SUM_W-1:0]                sum_voltage_2,
    output logic [WIN_W-1:0]                batch_samples
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_ACCUM  = 2'd2;
    localparam logic [1:0] ST_DIVIDE = 2'd3;

    logic [1:0]                 state_reg;
    logic [WIN_W-1:0]           window_reg;
    logic signed [VOFF_W-1:0]   voffset_reg;
    logic signed [OFFSET_W-1:0] coffset_1_reg;
    logic signed [OFFSET_W-1:0] coffset_2_reg;
    logic signed [OFFSET_W-1:0] voffset_ext;
    logic signed [CALIB_W-1:0]  calib_sum_1_reg;
    logic signed [CALIB_W-1:0]  calib_sum_2_reg;
    logic [CNT_W-1:0]           calib_count_reg;
    logic [WIN_W-1:0]           batch_count_reg;
    logic [WIN_W-1:0]           count_next;
    logic [WIN_W-1:0]           win_eff;
    logic                       complete;
    logic                       out_valid_reg;
    logic [SUM_W-1:0]           out_c1_reg;
    logic [SUM_W-1:0]           out_c2_reg;
    logic [SUM_W-1:0]           out_v1_reg;
    logic [SUM_W-1:0]           out_v2_reg;
    logic [WIN_W-1:0]           out_count_reg;
    logic                       accept;
    logic                       cfg_write;
    logic                       accum_go;
    logic                       div_start;
    logic                       div_done;
    logic                       div1_done;
    logic                       div2_done;
    logic signed [OFFSET_W-1:0] quo_1;
    logic signed [OFFSET_W-1:0] quo_2;
    lane_ctrl_t                 lane_ctrl;
    logic [SUM_W-1:0]           lane_sum_c1;
    logic [SUM_W-1:0]           lane_sum_c2;
    logic [SUM_W-1:0]           lane_sum_v1;
    logic [SUM_W-1:0]           lane_sum_v2;

    // Saturating 32-bit add of one calibration sample
    function automatic logic signed [CALIB_W-1:0] sat_add32(
        input logic signed [CALIB_W-1:0]  acc,
        input logic signed [SAMPLE_W-1:0] smp
    );
        logic [CALIB_W:0] wide;
        wide = {acc[CALIB_W-1], acc} + {{(CALIB_W+1-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        if (wide[CALIB_W] != wide[CALIB_W-1])
        begin
            sat_add32 = wide[CALIB_W] ? {1'b1, {(CALIB_W-1){1'b0}}}
                                      : {1'b0, {(CALIB_W-1){1'b1}}};
        end
        else
        begin
            sat_add32 = wide[CALIB_W-1:0];
        end
    endfunction

    // Handshakes
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read back
    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW:  prdata = {{(32-WIN_W){1'b0}}, window_reg};
            REG_VOFFSET: prdata = {{(32-VOFF_W){voffset_reg[VOFF_W-1]}}, voffset_reg};
            default:     prdata = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WIN_W'(200);
            voffset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW:  window_reg  <= pwdata[WIN_W-1:0];
                REG_VOFFSET: voffset_reg <= pwdata[VOFF_W-1:0];
                default:     ;
            endcase
        end
    end

    // Window clamp and batch completion
    assign win_eff = (window_reg == '0) ? WIN_W'(1) :
                     (window_reg > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_reg;
    assign count_next = batch_count_reg + 1'b1;
    assign complete   = count_next >= win_eff;
    assign accum_go   = (state_reg == ST_ACCUM) && !(complete && out_valid_reg && out_stall);

    // Lane strobes
    always_comb
    begin
        lane_ctrl.load   = accept && (mode == MODE_MEASURE);
        lane_ctrl.square = (state_reg == ST_SQUARE);
        lane_ctrl.accum  = accum_go;
        lane_ctrl.clear  = complete;
    end

    assign voffset_ext = {voffset_reg[VOFF_W-1], voffset_reg};

    omsa_lane u_lane_c1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .sample   (sample_current_1),
        .offset   (coffset_1_reg),
        .sum_next (lane_sum_c1)
    );

    omsa_lane u_lane_c2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .sample   (sample_current_2),
        .offset   (coffset_2_reg),
        .sum_next (lane_sum_c2)
    );

    omsa_lane u_lane_v1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .sample   (sample_voltage_1),
        .offset   (voffset_ext),
        .sum_next (lane_sum_v1)
    );

    omsa_lane u_lane_v2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lane_ctrl),
        .sample   (sample_voltage_2),
        .offset   (voffset_ext),
        .sum_next (lane_sum_v2)
    );

    // Offset dividers
    assign div_start = accept && (mode == MODE_FINISH) && (calib_count_reg != '0);
    assign div_done  = div1_done && div2_done;

    omsa_div u_div_1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (calib_sum_1_reg),
        .divisor  (calib_count_reg),
        .done     (div1_done),
        .quotient (quo_1)
    );

    omsa_div u_div_2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (calib_sum_2_reg),
        .divisor  (calib_count_reg),
        .done     (div2_done),
        .quotient (quo_2)
    );

    // Sequencer, calibration and batch count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            coffset_1_reg   <= '0;
            coffset_2_reg   <= '0;
            calib_sum_1_reg <= '0;
            calib_sum_2_reg <= '0;
            calib_count_reg <= '0;
            batch_count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode)
                            MODE_MEASURE:
                            begin
                                state_reg <= ST_SQUARE;
                            end
                            MODE_CALIB:
                            begin
                                if (calib_count_reg != CNT_W'(MAX_CALIB))
                                begin
                                    calib_sum_1_reg <= sat_add32(calib_sum_1_reg,
                                                                 sample_current_1);
                                    calib_sum_2_reg <= sat_add32(calib_sum_2_reg,
                                                                 sample_current_2);
                                    calib_count_reg <= calib_count_reg + 1'b1;
                                end
                            end
                            MODE_FINISH:
                            begin
                                if (calib_count_reg != '0)
                                begin
                                    state_reg <= ST_DIVIDE;
                                end
                                else
                                begin
                                    calib_sum_1_reg <= '0;
                                    calib_sum_2_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SQUARE:
                begin
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    if (accum_go)
                    begin
                        batch_count_reg <= complete ? '0 : count_next;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        coffset_1_reg   <= quo_1;
                        coffset_2_reg   <= quo_2;
                        calib_sum_1_reg <= '0;
                        calib_sum_2_reg <= '0;
                        calib_count_reg <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Merge stage: output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accum_go && complete)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Merge stage: batch payload
    always_ff @(posedge clk)
    begin
        if (accum_go && complete)
        begin
            out_c1_reg    <= lane_sum_c1;
            out_c2_reg    <= lane_sum_c2;
            out_v1_reg    <= lane_sum_v1;
            out_v2_reg    <= lane_sum_v2;
            out_count_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sum_current_1 = out_c1_reg;
    assign sum_current_2 = out_c2_reg;
    assign sum_voltage_1 = out_v1_reg;
    assign sum_voltage_2 = out_v2_reg;
    assign batch_samples = out_count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/omsa_lane.sv =====
// One channel lane: offset subtract, square, saturating accumulate.
`default_nettype none

module omsa_lane
    import omsa_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [OFFSET_W-1:0] offset,
    output logic [SUM_W-1:0]                sum_next
);

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [DIFF_W-1:0] scaled;
    logic signed [DIFF_W-1:0] off_ext;
    logic [MAG_W-1:0]         mag;
    logic [SQ_W-1:0]          sq_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W:0]           sum_wide;

    // Sample moved to fixed point, offset removed
    assign scaled = {{(DIFF_W-SAMPLE_W-FRAC_BITS){sample[SAMPLE_W-1]}}, sample,
                     {FRAC_BITS{1'b0}}};
    assign off_ext   = {{(DIFF_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};
    assign diff_next = scaled - off_ext;

    // Magnitude for the square
    assign mag = diff_reg[DIFF_W-1] ? MAG_W'(-diff_reg) : MAG_W'(diff_reg);

    // Saturating running sum
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(sq_reg);
    assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            diff_reg <= diff_next;
        end
        if (ctrl.square)
        begin
            sq_reg <= mag * mag;
        end
    end

    // Accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.accum)
        begin
            sum_reg <= ctrl.clear ? '0 : sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/omsa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the offset average.
`default_nettype none

module omsa_div
    import omsa_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [CALIB_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]          divisor,
    output logic                           done,
    output logic signed [OFFSET_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic [CNT_W-1:0]      rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CNT_W-1:0]      div_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic [CALIB_W-1:0]    abs_dividend;
    logic [CNT_W:0]        shifted;
    logic                  fits;
    logic [DIVIDEND_W-1:0] signed_quo;

    assign abs_dividend = dividend[CALIB_W-1] ? (~dividend + 1'b1) : dividend;

    // One restoring step
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    // Truncation toward zero: divide magnitudes, then restore the sign
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[OFFSET_W-1:0];
    assign done       = done_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= {abs_dividend, {FRAC_BITS{1'b0}}};
            div_reg <= divisor;
            neg_reg <= dividend[CALIB_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(shifted - {1'b0, div_reg}) : CNT_W'(shifted);
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

// ===== tb/offset_mean_square_accumulator_tb.sv =====
// Self-checking testbench for the offset mean-square accumulator.
`timescale 1ns / 1ps

module offset_mean_square_accumulator_tb
    import omsa_pkg::*;
();

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int DRAIN_CYCLES = 64;   // longer than a finish with a nonzero count
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [SAMPLE_W-1:0] cur1;
        logic signed [SAMPLE_W-1:0] cur2;
        logic signed [SAMPLE_W-1:0] volt1;
        logic signed [SAMPLE_W-1:0] volt2;
    } sample_item_t;

    // Lane order: current 1, current 2, voltage 1, voltage 2
    typedef struct packed {
        logic [3:0][SUM_W-1:0] sums;
        logic [WIN_W-1:0]      count;
    } batch_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        sample_item_t item;
        logic         typed;
        batch_t       want;
        logic         reg_idx;
        logic [31:0]  reg_data;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire  pready;
    logic in_valid;
    wire  in_stall;
    logic [1:0] mode;
    logic signed [SAMPLE_W-1:0] sample_current_1, sample_current_2;
    logic signed [SAMPLE_W-1:0] sample_voltage_1, sample_voltage_2;
    wire  out_valid;
    logic out_stall;
    wire  [SUM_W-1:0] sum_current_1, sum_current_2, sum_voltage_1, sum_voltage_2;
    wire  [WIN_W-1:0] batch_samples;

    // Predictor state and configuration
    logic [WIN_W-1:0]        cfg_window = WIN_W'(200);
    logic signed [VOFF_W-1:0] cfg_voff  = '0;
    longint                  off_c1 = 0, off_c2 = 0;
    longint                  cal_sum1 = 0, cal_sum2 = 0;
    int                      cal_cnt = 0;
    logic [3:0][SUM_W-1:0]   acc = '0;
    int                      acc_cnt = 0;

    batch_t pending_batches[$];
    batch_t seen_batch, oldest_batch;
    int     errors = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    logic   hold_go = 1'b0;

    offset_mean_square_accumulator DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .sample_current_1 (sample_current_1),
        .sample_current_2 (sample_current_2),
        .sample_voltage_1 (sample_voltage_1),
        .sample_voltage_2 (sample_voltage_2),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sum_current_1    (sum_current_1),
        .sum_current_2    (sum_current_2),
        .sum_voltage_1    (sum_voltage_1),
        .sum_voltage_2    (sum_voltage_2),
        .batch_samples    (batch_samples)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Square of (sample in Q.8 minus offset), saturated to the sum width
    function automatic logic [SUM_W-1:0] lane_square(input longint s, input longint off);
        longint          d;
        longint unsigned mag;
        longint unsigned sq;
        d   = s * (longint'(1) << FRAC_BITS) - off;
        mag = (d < 0) ? -d : d;
        if (mag > 64'hFFFF_FFFF)
            return SUM_MAX;
        sq = mag * mag;
        return (sq > SUM_MAX) ? SUM_MAX : sq[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] r;
        r = a + b;
        return r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Advance the predicted accumulator by one accepted transaction
    task automatic advance_accumulator(input sample_item_t it, output bit produced,
                                       output batch_t b);
        int win;
        produced = 1'b0;
        b        = '0;
        case (it.mode)
            MODE_CALIB:
            begin
                if (cal_cnt < MAX_CALIB)
                begin
                    cal_sum1 = clamp32(cal_sum1 + longint'($signed(it.cur1)));
                    cal_sum2 = clamp32(cal_sum2 + longint'($signed(it.cur2)));
                    cal_cnt++;
                end
            end
            MODE_FINISH:
            begin
                // zero count keeps the old offsets
                if (cal_cnt != 0)
                begin
                    off_c1 = cal_sum1 * (longint'(1) << FRAC_BITS) / longint'(cal_cnt);
                    off_c2 = cal_sum2 * (longint'(1) << FRAC_BITS) / longint'(cal_cnt);
                end
                cal_sum1 = 0;
                cal_sum2 = 0;
                cal_cnt  = 0;
            end
            MODE_MEASURE:
            begin
                acc[0] = sat_add(acc[0], lane_square(longint'($signed(it.cur1)), off_c1));
                acc[1] = sat_add(acc[1], lane_square(longint'($signed(it.cur2)), off_c2));
                acc[2] = sat_add(acc[2], lane_square(longint'($signed(it.volt1)),
                                                     longint'(cfg_voff)));
                acc[3] = sat_add(acc[3], lane_square(longint'($signed(it.volt2)),
                                                     longint'(cfg_voff)));
                acc_cnt++;
                win = int'(cfg_window);
                if (win < 1)
                    win = 1;
                if (win > MAX_WINDOW)
                    win = MAX_WINDOW;
                if (acc_cnt >= win)
                begin
                    produced = 1'b1;
                    b.sums   = acc;
                    b.count  = WIN_W'(acc_cnt);
                    acc      = '0;
                    acc_cnt  = 0;
                end
            end
            default:
            begin
                // mode three: dropped
            end
        endcase
    endtask

    // Offer one transaction, wait for acceptance, then record its prediction
    task automatic send(input sample_item_t it, input bit typed, input batch_t want);
        bit     produced;
        batch_t b;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid         <= 1'b1;
        mode             <= it.mode;
        sample_current_1 <= it.cur1;
        sample_current_2 <= it.cur2;
        sample_voltage_1 <= it.volt1;
        sample_voltage_2 <= it.volt2;
        do @(posedge clk); while (in_stall);
        advance_accumulator(it, produced, b);
        if (produced)
            pending_batches.push_back(typed ? want : b);
    endtask

    // Let all outstanding work finish before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_batches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic reg_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WINDOW)
            cfg_window = data[WIN_W-1:0];
        else
            cfg_voff = data[VOFF_W-1:0];
    endtask

    task automatic set_phase(input logic [31:0] win, input logic [31:0] voff,
                             input int s_idle, input int r_idle);
        drain();
        reg_write(REG_WINDOW, win);
        reg_write(REG_VOFFSET, voff);
        send_idle = s_idle;
        recv_idle = r_idle;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3, 4:    return SAMPLE_W'(int'($urandom_range(512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic sample_item_t rand_item(input logic [1:0] m);
        sample_item_t it;
        it.mode  = m;
        it.cur1  = rand_sample();
        it.cur2  = rand_sample();
        it.volt1 = rand_sample();
        it.volt2 = rand_sample();
        return it;
    endfunction

    function automatic row_t item_row(input logic [1:0] m, input int c1, input int c2,
                                      input int v1, input int v2);
        row_t r;
        r            = '0;
        r.kind       = ROW_ITEM;
        r.item.mode  = m;
        r.item.cur1  = SAMPLE_W'(c1);
        r.item.cur2  = SAMPLE_W'(c2);
        r.item.volt1 = SAMPLE_W'(v1);
        r.item.volt2 = SAMPLE_W'(v2);
        return r;
    endfunction

    // Measure with the same sample on all lanes under zero offsets, window 1
    function automatic row_t typed_row(input int c, input logic [SUM_W-1:0] sq);
        row_t r;
        r            = item_row(MODE_MEASURE, c, c, c, c);
        r.typed      = 1'b1;
        r.want.sums  = {4{sq}};
        r.want.count = WIN_W'(1);
        return r;
    endfunction

    function automatic row_t write_row(input logic idx, input logic [31:0] data);
        row_t r;
        r          = '0;
        r.kind     = ROW_WRITE;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Random traffic: mostly measure samples, calibration runs, some noise
    task automatic run_random(input int n_items);
        int           sent;
        int           k;
        int           dc1;
        int           dc2;
        sample_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(31))
                0:
                begin
                    // calibration run around a DC level, closed by a finish
                    k   = $urandom_range(1, 24);
                    dc1 = int'($urandom_range(4000)) - 2000;
                    dc2 = int'($urandom_range(4000)) - 2000;
                    repeat (k)
                    begin
                        it = rand_item(MODE_CALIB);
                        if ($urandom_range(7) != 0)
                        begin
                            it.cur1 = SAMPLE_W'(dc1 + int'($urandom_range(128)) - 64);
                            it.cur2 = SAMPLE_W'(dc2 + int'($urandom_range(128)) - 64);
                        end
                        send(it, 1'b0, '0);
                    end
                    send(rand_item(MODE_FINISH), 1'b0, '0);
                    sent += k + 1;
                end
                1:
                begin
                    // noise: dropped mode, stray finish, stray calibration sample
                    case ($urandom_range(2))
                        0: send(rand_item(MODE_IGNORED), 1'b0, '0);
                        1:
                        begin
                            send(rand_item(MODE_FINISH), 1'b0, '0);
                            sent++;
                        end
                        default:
                        begin
                            send(rand_item(MODE_CALIB), 1'b0, '0);
                            sent++;
                        end
                    endcase
                end
                default:
                begin
                    send(rand_item(MODE_MEASURE), 1'b0, '0);
                    sent++;
                end
            endcase
        end
    endtask

    // Receiver: random stalls, or a long counted hold when requested
    initial
    begin : receiver
        logic hold_seen;
        int   hold_left;
        out_stall = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go != hold_seen)
            begin
                hold_seen = hold_go;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Batch monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_batch.sums  = {sum_voltage_2, sum_voltage_1, sum_current_2, sum_current_1};
            seen_batch.count = batch_samples;
            if (pending_batches.size() == 0)
            begin
                $display("%0t: unexpected batch, count %0d", $time, seen_batch.count);
                errors++;
            end
            else
            begin
                oldest_batch = pending_batches.pop_front();
                for (int l = 0; l < 4; l++)
                begin
                    if (seen_batch.sums[l] !== oldest_batch.sums[l])
                    begin
                        $display("%0t: lane %0d sum expected %0d actual %0d", $time, l,
                                 oldest_batch.sums[l], seen_batch.sums[l]);
                        errors++;
                    end
                end
                if (seen_batch.count !== oldest_batch.count)
                begin
                    $display("%0t: batch_samples expected %0d actual %0d", $time,
                             oldest_batch.count, seen_batch.count);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial
    begin
        row_t dir_rows[$];

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        mode             = MODE_MEASURE;
        sample_current_1 = '0;
        sample_current_2 = '0;
        sample_voltage_1 = '0;
        sample_voltage_2 = '0;

        // Directed rows; typed expectations rely on reset offsets and window 1
        dir_rows.push_back(write_row(REG_WINDOW, 32'd1));
        dir_rows.push_back(typed_row(0, 60'd0));
        dir_rows.push_back(typed_row(-32768, 60'd70368744177664));
        dir_rows.push_back(typed_row(32767, 60'd70364449275904));
        dir_rows.push_back(item_row(MODE_IGNORED, 1234, -5, 77, -32768));
        // finish with nothing collected leaves offsets at zero
        dir_rows.push_back(item_row(MODE_FINISH, 0, 0, 0, 0));
        dir_rows.push_back(typed_row(0, 60'd0));
        dir_rows.push_back(item_row(MODE_CALIB, 1000, -1000, 0, 0));
        dir_rows.push_back(item_row(MODE_IGNORED, 32767, 32767, 32767, 32767));
        dir_rows.push_back(item_row(MODE_CALIB, 1001, -1003, 5, 5));
        dir_rows.push_back(item_row(MODE_CALIB, 1002, -1004, -5, -5));
        // negative average checks truncation toward zero
        dir_rows.push_back(item_row(MODE_FINISH, 0, 0, 0, 0));
        dir_rows.push_back(item_row(MODE_MEASURE, 1001, -1002, 100, -100));
        dir_rows.push_back(item_row(MODE_MEASURE, -32768, 32767, 32767, -32768));
        dir_rows.push_back(item_row(MODE_CALIB, -32768, 32767, 0, 0));
        dir_rows.push_back(item_row(MODE_CALIB, -32768, 32767, 0, 0));
        dir_rows.push_back(item_row(MODE_FINISH, 0, 0, 0, 0));
        // extreme offsets against opposite extreme samples
        dir_rows.push_back(item_row(MODE_MEASURE, 32767, -32768, 0, 0));
        dir_rows.push_back(write_row(REG_VOFFSET, 32'hFF80_0000));
        dir_rows.push_back(item_row(MODE_MEASURE, 0, 0, 32767, -32768));
        dir_rows.push_back(write_row(REG_VOFFSET, 32'h007F_FFFF));
        dir_rows.push_back(item_row(MODE_MEASURE, 0, 0, -32768, 32767));
        // window lowered below the running count
        dir_rows.push_back(write_row(REG_WINDOW, 32'd4));
        dir_rows.push_back(item_row(MODE_MEASURE, 10, 20, 30, 40));
        dir_rows.push_back(item_row(MODE_MEASURE, -10, -20, -30, -40));
        dir_rows.push_back(item_row(MODE_MEASURE, 300, -300, 3000, -3000));
        dir_rows.push_back(write_row(REG_WINDOW, 32'd2));
        dir_rows.push_back(item_row(MODE_MEASURE, 7, 7, 7, 7));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_WRITE)
            begin
                drain();
                reg_write(dir_rows[r].reg_idx, dir_rows[r].reg_data);
            end
            else
                send(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end

        // Random phases over several settings and idling patterns
        set_phase(32'd8, $urandom, 0, 0);
        run_random(150);
        set_phase(32'd1, 32'd0, 56, 0);
        run_random(150);
        // all ones: window clamps to the maximum, offset is -1
        set_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 56);
        run_random(120);
        set_phase(32'd3, $urandom, 34, 34);
        run_random(150);
        // window zero clamps to one; long receiver hold fills the pipeline
        set_phase(32'd0, $urandom, 0, 0);
        hold_go <= ~hold_go;
        run_random(100);
        set_phase(32'd17, $urandom, 34, 34);
        run_random(200);
        set_phase(32'd4096, $urandom, 56, 0);
        run_random(60);
        set_phase(32'd5, $urandom, 0, 56);
        run_random(170);

        // Close with a finish and a short run of measure samples
        set_phase(32'd1, 32'd0, 0, 0);
        send(rand_item(MODE_FINISH), 1'b0, '0);
        repeat (20) send(rand_item(MODE_MEASURE), 1'b0, '0);

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/omsa_pkg.sv
rtl/core/omsa_lane.sv
rtl/core/omsa_div.sv
rtl/core/offset_mean_square_accumulator.sv
tb/offset_mean_square_accumulator_tb.sv
